>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SA_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sa assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sa assertion failed");

`endif

>>> hw/rtl/sa_pkg.sv
// Types and constants of the stack allocator.
package sa_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned POOL_W     = 25;
	localparam int unsigned SIZE_W     = 24;
	localparam int unsigned ALOG_W     = 3;
	localparam int unsigned PAD_W      = 8;
	localparam int unsigned LIVE_W     = 7;
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL = 8'd1;

	localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;
	localparam logic [POOL_W-1:0] POOL_RESET = 25'd65536;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_FULL     = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SIZE_W-1:0] alloc_size;
		logic [ALOG_W-1:0] align_log2;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
		logic [POOL_W-1:0] bytes_in_use;
		logic [LIVE_W-1:0] live_blocks;
	} rsp_t;

	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [ADDR_W-1:0] addr;
	} stk_ent_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} stk_ctl_t;

endpackage

>>> hw/rtl/sa_if.sv
// Request, response and configuration channels of the stack allocator.
interface sa_req_if;
	import sa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sa_rsp_if;
	import sa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sa_cfg_if;
	import sa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

>>> hw/rtl/sa_stack.sv
// Block stack: entry memory, cached top entry and prefetched entry below it.
module sa_stack #(
	parameter int unsigned MAX_ALLOCS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sa_pkg::stk_ctl_t                  ctl,
	input  sa_pkg::stk_ent_t                  push_ent,
	output sa_pkg::stk_ent_t                  top_ent,
	output logic [$clog2(MAX_ALLOCS+1)-1:0]   count
);
	import sa_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ALLOCS + 1);
	localparam int unsigned IW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
	localparam logic [CW:0] TWO = (CW + 1)'(2);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nx;
	logic [CW:0]   rd_diff;
	logic          rd_en;
	logic [IW-1:0] rd_idx;
	stk_ent_t      mem [MAX_ALLOCS];
	stk_ent_t      top_q;
	stk_ent_t      below_q;

	always_comb begin
		priority if (ctl.clr) begin
			count_nx = '0;
		end else if (ctl.push) begin
			count_nx = CW'(count_q + 1'b1);
		end else if (ctl.pop) begin
			count_nx = CW'(count_q - 1'b1);
		end else begin
			count_nx = count_q;
		end
	end

	// Prefetch the entry that becomes the top after a pop.
	assign rd_diff = {1'b0, count_nx} - TWO;
	assign rd_en   = {1'b0, count_nx} >= TWO;
	assign rd_idx  = rd_diff[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[count_q[IW-1:0]] <= push_ent;
		end
		if (rd_en) begin
			below_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q <= push_ent;
		end else if (ctl.pop) begin
			top_q <= below_q;
		end
	end

	assign top_ent = top_q;
	assign count   = count_q;

	`include "assert_macros.svh"

	`SA_ASSERT_NEXT(a_push_count, ctl.push && !ctl.clr, count_q == CW'($past(count_q) + 1'b1))
	`SA_ASSERT_NEXT(a_pop_count, ctl.pop && !ctl.clr, count_q == CW'($past(count_q) - 1'b1))

endmodule

>>> hw/rtl/sa_core.sv
// Allocator datapath: padding, space and stack checks, top and usage registers.
module sa_core #(
	parameter int unsigned MAX_ALLOCS   = 64,
	parameter int unsigned HEADER_BYTES = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sa_cfg_if.sink                            cfg,
	input  logic                              adv,
	input  sa_pkg::req_t                      req_s1,
	input  sa_pkg::stk_ent_t                  top_ent,
	input  logic [$clog2(MAX_ALLOCS+1)-1:0]   count,
	output sa_pkg::stk_ctl_t                  ctl,
	output sa_pkg::stk_ent_t                  push_ent,
	output sa_pkg::rsp_t                      rsp
);
	import sa_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ALLOCS + 1);
	localparam logic [PAD_W-1:0] HDR = PAD_W'(HEADER_BYTES);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ALLOCS);

	logic                  cfg_we;
	logic                  base_we;
	logic                  pool_we;
	logic [ADDR_W-1:0]     base_q;
	logic [POOL_W-1:0]     pool_q;
	logic [ADDR_W-1:0]     top_q;
	logic [POOL_W-1:0]     used_q;

	logic [PAD_W-1:0]      mask;
	logic [PAD_W-1:0]      pad0;
	logic [PAD_W-1:0]      need;
	logic [PAD_W-1:0]      pad_up;
	logic [PAD_W-1:0]      pad;
	logic [POOL_W:0]       total;
	logic [ADDR_W-1:0]     grant_addr;
	logic [ADDR_W-1:0]     freed;
	logic                  no_space;
	logic                  full;
	logic                  bad_free;

	logic [ADDR_W-1:0]     top_nx;
	logic [POOL_W-1:0]     used_nx;
	logic [CW-1:0]         live_nx;
	logic [ADDR_W-1:0]     granted;
	status_t               status;
	logic                  do_push;
	logic                  do_pop;
	logic                  do_clr;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign base_we   = cfg_we && (cfg.idx == REG_BASE);
	assign pool_we   = cfg_we && (cfg.idx == REG_POOL);

	// Pad the top to the alignment, then lift the pad to at least the header room.
	assign mask   = PAD_W'((PAD_W'(1) << req_s1.align_log2) - PAD_W'(1));
	assign pad0   = PAD_W'(~top_q[PAD_W-1:0] + PAD_W'(1)) & mask;
	assign need   = PAD_W'(HDR - pad0);
	assign pad_up = PAD_W'(need + mask) & ~mask;
	assign pad    = (pad0 < HDR) ? PAD_W'(pad0 + pad_up) : pad0;

	assign total      = (POOL_W + 1)'(used_q) + (POOL_W + 1)'(pad)
		+ (POOL_W + 1)'(req_s1.alloc_size);
	assign grant_addr = top_q + ADDR_W'(pad);
	assign no_space   = total > {1'b0, pool_q};
	assign full       = count >= CNT_MAX;
	assign bad_free   = (count == '0) || (top_ent.addr != req_s1.free_address);
	assign freed      = (top_q - req_s1.free_address) + ADDR_W'(top_ent.pad);

	always_comb begin
		top_nx  = top_q;
		used_nx = used_q;
		live_nx = count;
		granted = '0;
		status  = ST_OK;
		do_push = 1'b0;
		do_pop  = 1'b0;
		do_clr  = 1'b0;
		unique case (req_s1.req_type)
			REQ_ALLOC: begin
				if (no_space) begin
					status = ST_NO_SPACE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_push = 1'b1;
					granted = grant_addr;
					top_nx  = grant_addr + ADDR_W'(req_s1.alloc_size);
					used_nx = total[POOL_W-1:0];
					live_nx = CW'(count + 1'b1);
				end
			end
			REQ_FREE: begin
				if (bad_free) begin
					status = ST_BAD_FREE;
				end else begin
					do_pop  = 1'b1;
					top_nx  = req_s1.free_address - ADDR_W'(top_ent.pad);
					used_nx = used_q - freed[POOL_W-1:0];
					live_nx = CW'(count - 1'b1);
				end
			end
			REQ_CLEAR: begin
				do_clr  = 1'b1;
				top_nx  = base_q;
				used_nx = '0;
				live_nx = '0;
			end
			default: begin
			end
		endcase
	end

	assign ctl.push      = adv && !base_we && do_push;
	assign ctl.pop       = adv && !base_we && do_pop;
	assign ctl.clr       = base_we || (adv && do_clr);
	assign push_ent.pad  = pad;
	assign push_ent.addr = grant_addr;

	assign rsp.block_address = granted;
	assign rsp.status        = status;
	assign rsp.bytes_in_use  = used_nx;
	assign rsp.live_blocks   = LIVE_W'(live_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			pool_q <= POOL_RESET;
			top_q  <= BASE_RESET;
			used_q <= '0;
		end else begin
			if (pool_we) begin
				pool_q <= cfg.wdata[POOL_W-1:0];
			end
			if (base_we) begin
				base_q <= cfg.wdata;
				top_q  <= cfg.wdata;
				used_q <= '0;
			end else if (adv) begin
				top_q  <= top_nx;
				used_q <= used_nx;
			end
		end
	end

	`include "assert_macros.svh"

	`SA_ASSERT_SAME(a_grant_ok, rsp.block_address != '0, rsp.status == ST_OK)
	`SA_ASSERT_NEXT(a_push_top, ctl.push, top_ent.addr == $past(push_ent.addr))

endmodule

>>> hw/rtl/stack_allocator.sv
// Stack allocator top level: request register, datapath, block stack, result register.
//
// LIFO region allocator over a pool of pool_size bytes starting at base_address.
// Channels: req (sink) takes one request word, rsp (source) returns exactly
// one result word per request, in order; cfg (sink) writes register 0
// (base_address, which also empties the allocator) or register 1 (pool_size).
// cfg is always ready; it must be written only while no request is in flight,
// which the block itself does not enforce. A request is registered, processed
// by the datapath and its result held in the result register, which drives
// rsp. Throughput: one request per cycle while rsp is not held off; the top,
// usage and stack pointer are updated between the request and result registers,
// and the stack memory prefetches the entry below the top so a free never waits.
// Reset: pool empty, top at address 0, pool_size 65536, no live blocks; the
// stack memory needs no clearing pass.
// Stall: while rsp is held off, the result register keeps its word and one
// more request waits in the request register; req then drops ready.
module stack_allocator #(
	parameter int unsigned MAX_ALLOCS   = 64,
	parameter int unsigned HEADER_BYTES = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	sa_cfg_if.sink     cfg,
	sa_req_if.sink     req,
	sa_rsp_if.source   rsp
);
	import sa_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ALLOCS + 1);

	logic           valid_s1;
	req_t           req_s1;
	logic           out_valid_q;
	rsp_t           rsp_q;
	logic           adv;
	stk_ctl_t       ctl;
	stk_ent_t       push_ent;
	stk_ent_t       top_ent;
	logic [CW-1:0]  count;
	rsp_t           core_rsp;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	sa_core #(
		.MAX_ALLOCS   (MAX_ALLOCS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.adv      (adv),
		.req_s1   (req_s1),
		.top_ent  (top_ent),
		.count    (count),
		.ctl      (ctl),
		.push_ent (push_ent),
		.rsp      (core_rsp)
	);

	sa_stack #(
		.MAX_ALLOCS (MAX_ALLOCS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.push_ent (push_ent),
		.top_ent  (top_ent),
		.count    (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

endmodule
